### rtl/hdrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrs_pkg
// Shared types and constants of the hybrid DRAM refresh scheduler.
// ----------------------------------------------------------------------------
package hdrs_pkg;

    localparam int NUM_BANKS  = 8;
    localparam int BANK_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BANKS + 1);
    localparam int MASK_IN_W  = 8;
    localparam int TIME_W     = 48;
    localparam int IVL_W      = 32;
    localparam int LIM_W      = 7;
    localparam int DEBT_W     = 8;
    localparam int ICMD_W     = 4;
    localparam int RCMD_W     = 3;
    localparam int TARGET_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 56;

    localparam logic [TIME_W-1:0] TIME_MAX          = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] FIRST_TRIGGER_RST = 48'd488;
    localparam logic [IVL_W-1:0]  BANK_IVL_RST      = 32'd488;
    localparam logic [IVL_W-1:0]  ALL_BANK_IVL_RST  = 32'd3904;
    localparam logic [LIM_W-1:0]  POSTPONE_RST      = 7'd64;
    localparam logic [DEBT_W-1:0] PULLIN_RST        = 8'hC0;   // -64
    localparam logic [LIM_W-1:0]  PANIC_RST         = 7'd32;

    typedef logic [NUM_BANKS-1:0] bank_mask_t;
    localparam bank_mask_t ALL_BANKS = {NUM_BANKS{1'b1}};

    // Commands issued by the controller, as reported back to the scheduler
    localparam logic [ICMD_W-1:0] ICMD_ACT   = 4'd0;
    localparam logic [ICMD_W-1:0] ICMD_PREAB = 4'd1;
    localparam logic [ICMD_W-1:0] ICMD_PREPB = 4'd2;
    localparam logic [ICMD_W-1:0] ICMD_REFPB = 4'd3;
    localparam logic [ICMD_W-1:0] ICMD_REFAB = 4'd4;
    localparam logic [ICMD_W-1:0] ICMD_PDE   = 4'd5;
    localparam logic [ICMD_W-1:0] ICMD_SREFE = 4'd6;
    localparam logic [ICMD_W-1:0] ICMD_PDX   = 4'd7;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BANK_IVL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_BANK_IVL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSTPONE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULLIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PANIC        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TRIG   = 3'd5;

    typedef enum logic [RCMD_W-1:0] {
        RCMD_NOP   = 3'd0,
        RCMD_PREPB = 3'd1,
        RCMD_REFPB = 3'd2,
        RCMD_PREAB = 3'd3,
        RCMD_REFAB = 3'd4
    } refresh_cmd_t;

    typedef struct packed {
        logic [IVL_W-1:0]         bank_ivl;
        logic [IVL_W-1:0]         all_bank_ivl;
        logic [LIM_W-1:0]         postpone_limit;
        logic signed [DEBT_W-1:0] pullin_limit;
        logic [LIM_W-1:0]         panic_threshold;
    } cfg_t;

    typedef struct packed {
        logic                 kind;
        logic [TIME_W-1:0]    now;
        logic [ICMD_W-1:0]    issued_cmd;
        logic [MASK_IN_W-1:0] idle_mask;
        logic [MASK_IN_W-1:0] open_mask;
    } item_t;

    typedef struct packed {
        refresh_cmd_t        refresh_cmd;
        logic [TARGET_W-1:0] target_bank;
        logic                block_bank;
        logic                wake_request;
        logic [TIME_W-1:0]   next_trigger;
    } result_t;

endpackage

### rtl/hybrid_dram_refresh_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_dram_refresh_scheduler_top
// Per-rank DRAM refresh scheduler with per-bank postpone/pull-in and an
// all-bank fallback once the refresh debt grows too high.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_*): one word per evaluate tick (s_tuser = 0) carrying the
//   current time and the per-bank idle/open masks, or per command report
//   (s_tuser = 1) naming the command the controller just issued.
//   Master stream (m_*): exactly one result word per input word, in order:
//   the refresh command to issue, its bank, the block and wake flags, and
//   the trigger time after the step.
//   Config channel (cfg_*): one register per accepted word; always ready.
//   Write it only while no word is in flight.
// Timing:
//   The input register feeds one pass of the scheduler logic into the result
//   register; one word per cycle while m_tready is high, bounded by the bank
//   priority encoder and the 49-bit trigger add/compare.
// Reset:
//   rst_n clears both stages, loads the trigger with the reset first-trigger
//   time and the config and scheduler state registers with their defaults.
// Backpressure:
//   When m_tready is low the result holds; the input register still takes
//   one more word, then s_tready drops until the result drains.
// ----------------------------------------------------------------------------
module hybrid_dram_refresh_scheduler_top
    import hdrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // now[47:0], issued_cmd[51:48],
                                             // idle_mask[59:52], open_mask[67:60]
    input  logic                  s_tuser,   // kind
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // refresh_cmd[2:0], target_bank[5:3],
                                             // block_bank[6], wake_request[7],
                                             // next_trigger[55:8]
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   in_item_reg, in_item_next;
    logic    in_valid_reg, in_valid_next;
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    logic    s_accept;

    // Config registers never stall.
    assign cfg_ready = 1'b1;

    hdrs_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move a word from the input register into the result register when the
    // result slot is empty or being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_item_next            = in_item_reg;
        in_valid_next           = in_valid_reg;
        if (s_accept)
        begin
            in_item_next.kind       = s_tuser;
            in_item_next.now        = s_tdata[47:0];
            in_item_next.issued_cmd = s_tdata[51:48];
            in_item_next.idle_mask  = s_tdata[59:52];
            in_item_next.open_mask  = s_tdata[67:60];
            in_valid_next           = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    hdrs_sched_core u_sched_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (out_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: hold unless a new word lands.
    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        if (advance)
            out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.next_trigger, out_reg.wake_request, out_reg.block_bank,
                       out_reg.target_bank, out_reg.refresh_cmd};

endmodule

### rtl/hdrs_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrs_cfg_regs
// Configuration register file; one register written per accepted word.
// ----------------------------------------------------------------------------
module hdrs_cfg_regs
    import hdrs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_BANK_IVL:     cfg_next.bank_ivl        = wr_data[IVL_W-1:0];
                CFG_ALL_BANK_IVL: cfg_next.all_bank_ivl    = wr_data[IVL_W-1:0];
                CFG_POSTPONE:     cfg_next.postpone_limit  = wr_data[LIM_W-1:0];
                CFG_PULLIN:       cfg_next.pullin_limit    = $signed(wr_data[DEBT_W-1:0]);
                CFG_PANIC:        cfg_next.panic_threshold = wr_data[LIM_W-1:0];
                // first trigger only matters at reset, where it holds its reset value
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bank_ivl        <= BANK_IVL_RST;
            cfg_reg.all_bank_ivl    <= ALL_BANK_IVL_RST;
            cfg_reg.postpone_limit  <= POSTPONE_RST;
            cfg_reg.pullin_limit    <= $signed(PULLIN_RST);
            cfg_reg.panic_threshold <= PANIC_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/hdrs_sched_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdrs_sched_core
// Scheduler state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
module hdrs_sched_core
    import hdrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [TIME_W-1:0]        trigger_reg, trigger_next;
    logic signed [DEBT_W-1:0] debt_reg, debt_next;
    logic                     pulled_reg, pulled_next;
    logic                     panic_reg, panic_next;
    logic                     asleep_reg, asleep_next;
    logic                     keep_reg, keep_next;
    bank_mask_t               remaining_reg, remaining_next;
    logic [BANK_W-1:0]        chosen_reg, chosen_next;
    logic [CNT_W-1:0]         open_cnt_reg, open_cnt_next;

    function automatic logic [BANK_W-1:0] lowest_bank(input bank_mask_t m);
        logic [BANK_W-1:0] idx;
        idx = '0;
        for (int i = NUM_BANKS - 1; i >= 0; i--)
        begin
            if (m[i])
                idx = BANK_W'(i);
        end
        return idx;
    endfunction

    function automatic bank_mask_t to_banks(input logic [MASK_IN_W-1:0] m);
        bank_mask_t b;
        b = '0;
        for (int i = 0; i < NUM_BANKS; i++)
        begin
            if (i < MASK_IN_W)
                b[i] = m[i % MASK_IN_W];
        end
        return b;
    endfunction

    function automatic logic [TIME_W-1:0] sat_time(input logic [TIME_W:0] s);
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    logic [TIME_W:0]          sum_one, sum_two, sum_now_bank, sum_now_all;
    logic [TIME_W-1:0]        step_one, step_two;
    logic                     due, catchup, forced, panic_hit;
    bank_mask_t               idle_v, open_v, cand, rem_clr, rem_new;
    logic [BANK_W-1:0]        low_cand, low_rem, low_new, chosen_sel;
    logic signed [DEBT_W:0]   debt_ext;
    logic signed [DEBT_W-1:0] debt_inc, debt_dec, debt_after;
    logic                     pi_one, busy;
    logic [TIME_W-1:0]        t_one, t_plus;

    always_comb
    begin
        sum_one      = {1'b0, trigger_reg} + (TIME_W+1)'(cfg.bank_ivl);
        sum_two      = {1'b0, trigger_reg} + (TIME_W+1)'({cfg.bank_ivl, 1'b0});
        sum_now_bank = {1'b0, item.now} + (TIME_W+1)'(cfg.bank_ivl);
        sum_now_all  = {1'b0, item.now} + (TIME_W+1)'(cfg.all_bank_ivl);
        step_one     = sat_time(sum_one);
        step_two     = sat_time(sum_two);
        due          = item.now >= trigger_reg;
        catchup      = {1'b0, item.now} >= sum_one;

        idle_v   = to_banks(item.idle_mask);
        open_v   = to_banks(item.open_mask);
        cand     = remaining_reg & idle_v;
        low_cand = lowest_bank(cand);
        low_rem  = lowest_bank(remaining_reg);
        rem_clr  = remaining_reg & ~(bank_mask_t'(1) << chosen_reg);
        rem_new  = (rem_clr == '0) ? ALL_BANKS : rem_clr;
        low_new  = lowest_bank(rem_new);

        debt_ext  = {debt_reg[DEBT_W-1], debt_reg};
        forced    = debt_ext >= $signed({2'b00, cfg.postpone_limit});
        panic_hit = debt_ext >= $signed({2'b00, cfg.panic_threshold});
        debt_inc  = (debt_reg == 8'sd127)  ? debt_reg : debt_reg + 8'sd1;
        debt_dec  = (debt_reg == -8'sd128) ? debt_reg : debt_reg - 8'sd1;
        debt_after = pulled_reg ? debt_dec : debt_reg;

        pi_one  = catchup ? 1'b0 : pulled_reg;
        t_one   = catchup ? step_one : trigger_reg;
        t_plus  = catchup ? step_two : step_one;
        busy       = 1'b1;
        chosen_sel = chosen_reg;

        trigger_next   = trigger_reg;
        debt_next      = debt_reg;
        pulled_next    = pulled_reg;
        panic_next     = panic_reg;
        asleep_next    = asleep_reg;
        keep_next      = keep_reg;
        remaining_next = remaining_reg;
        chosen_next    = chosen_reg;
        open_cnt_next  = open_cnt_reg;

        result.refresh_cmd  = RCMD_NOP;
        result.target_bank  = '0;
        result.block_bank   = 1'b0;
        result.wake_request = 1'b0;

        if (item.kind)
        begin
            // report of an issued command
            if (item.issued_cmd == ICMD_ACT)
            begin
                if (open_cnt_reg < CNT_W'(NUM_BANKS))
                    open_cnt_next = open_cnt_reg + CNT_W'(1);
            end
            else if (item.issued_cmd == ICMD_PREAB)
            begin
                open_cnt_next = '0;
            end
            else if (item.issued_cmd == ICMD_PREPB)
            begin
                if (open_cnt_reg != '0)
                    open_cnt_next = open_cnt_reg - CNT_W'(1);
            end

            if (item.issued_cmd == ICMD_REFPB)
            begin
                keep_next      = 1'b0;
                remaining_next = rem_new;
                chosen_next    = low_new;
                debt_next      = debt_after;
                pulled_next    = 1'b1;
                if (debt_after <= cfg.pullin_limit)
                begin
                    pulled_next  = 1'b0;
                    trigger_next = step_one;
                end
            end
            else if (item.issued_cmd == ICMD_REFAB)
            begin
                pulled_next    = 1'b0;
                asleep_next    = 1'b0;
                trigger_next   = asleep_reg ? sat_time(sum_now_bank) : sat_time(sum_now_all);
                remaining_next = ALL_BANKS;
                chosen_next    = '0;
                keep_next      = 1'b0;
                panic_next     = 1'b0;
                if (debt_reg > DEBT_W'(NUM_BANKS))
                    debt_next = debt_reg - DEBT_W'(NUM_BANKS);
                else if (debt_reg > 8'sd0)
                    debt_next = '0;
            end
            else if (item.issued_cmd == ICMD_PDE)
            begin
                asleep_next = 1'b1;
            end
            else if (item.issued_cmd == ICMD_SREFE)
            begin
                asleep_next  = 1'b1;
                trigger_next = TIME_MAX;
            end
            else if (item.issued_cmd == ICMD_PDX)
            begin
                asleep_next = 1'b0;
            end
        end
        else if (due)
        begin
            result.wake_request = 1'b1;
            if (!asleep_reg)
            begin
                trigger_next = t_one;
                pulled_next  = pi_one;
                if (!pi_one)
                begin
                    if (panic_reg || panic_hit)
                    begin
                        panic_next         = 1'b1;
                        result.refresh_cmd = (open_cnt_reg != '0) ? RCMD_PREAB : RCMD_REFAB;
                    end
                    else
                    begin
                        if (!keep_reg)
                        begin
                            chosen_sel = (cand != '0) ? low_cand : low_rem;
                            busy       = (cand == '0);
                        end
                        chosen_next = chosen_sel;
                        if (busy && !forced)
                        begin
                            debt_next    = debt_inc;
                            trigger_next = t_plus;
                        end
                        else
                        begin
                            result.refresh_cmd = open_v[chosen_sel] ? RCMD_PREPB : RCMD_REFPB;
                            result.target_bank = TARGET_W'(chosen_sel);
                            if (forced)
                            begin
                                result.block_bank = 1'b1;
                                keep_next         = 1'b1;
                            end
                        end
                    end
                end
                else if (cand == '0)
                begin
                    pulled_next  = 1'b0;
                    trigger_next = step_one;
                end
                else
                begin
                    chosen_next        = low_cand;
                    result.refresh_cmd = open_v[low_cand] ? RCMD_PREPB : RCMD_REFPB;
                    result.target_bank = TARGET_W'(low_cand);
                end
            end
        end

        result.next_trigger = trigger_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg   <= FIRST_TRIGGER_RST;
            debt_reg      <= '0;
            pulled_reg    <= 1'b0;
            panic_reg     <= 1'b0;
            asleep_reg    <= 1'b0;
            keep_reg      <= 1'b0;
            remaining_reg <= ALL_BANKS;
            chosen_reg    <= '0;
            open_cnt_reg  <= '0;
        end
        else if (advance)
        begin
            trigger_reg   <= trigger_next;
            debt_reg      <= debt_next;
            pulled_reg    <= pulled_next;
            panic_reg     <= panic_next;
            asleep_reg    <= asleep_next;
            keep_reg      <= keep_next;
            remaining_reg <= remaining_next;
            chosen_reg    <= chosen_next;
            open_cnt_reg  <= open_cnt_next;
        end
    end

endmodule
